>>> rtl/core/mte_pkg.sv
// Shared types and constants for the machine-mode trap entry unit.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package mte_pkg;

	// request commands
	localparam logic [1:0] CMD_IRQ_CHECK = 2'd0;
	localparam logic [1:0] CMD_EXCEPTION = 2'd1;
	localparam logic [1:0] CMD_STATUS_WR = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAP_VECTOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE  = 1'd1;

	// status word fields
	localparam logic [31:0] MSTATUS_CLEAR_MASK  = 32'h0000_1888;
	localparam logic [31:0] MSTATUS_MPP_MACHINE = 32'h0000_1800;
	localparam int unsigned MSTATUS_MIE_BIT  = 3;
	localparam int unsigned MSTATUS_MPIE_BIT = 7;
	localparam logic [31:0] VECTOR_ALIGN_MASK = 32'hFFFF_FFFC;

	// interrupt lines and causes
	localparam int unsigned IRQ_LINE_SOFTWARE = 0;
	localparam int unsigned IRQ_LINE_TIMER    = 1;
	localparam int unsigned IRQ_LINE_EXTERNAL = 2;
	localparam logic [3:0] IRQ_CAUSE_SOFTWARE = 4'd3;
	localparam logic [3:0] IRQ_CAUSE_TIMER    = 4'd7;
	localparam logic [3:0] IRQ_CAUSE_EXTERNAL = 4'd11;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] current_pc;
		logic [2:0]  pending_lines;
		logic [3:0]  exception_cause;
		logic [31:0] fault_value;
		logic [31:0] status_value;
	} req_item_t;

	typedef struct packed {
		logic        trap_taken;
		logic        interrupt_taken;
		logic [31:0] redirect_pc;
		logic        halted_flag;
		logic [31:0] cause_now;
		logic [31:0] saved_pc;
		logic [31:0] status_now;
	} res_item_t;

	// architectural state seen by the entry logic
	typedef struct packed {
		logic [31:0] status;
		logic [31:0] epc;
		logic [31:0] cause;
		logic [31:0] trap_vector;
		logic [2:0]  irq_enable;
		logic        stopped;
	} csr_state_t;

	// state update produced by the entry logic for one request
	typedef struct packed {
		logic        commit;
		logic        halt;
		logic        status_wr;
		logic [31:0] status;
		logic [31:0] epc;
		logic [31:0] cause;
		logic [31:0] tval;
	} csr_update_t;

endpackage

>>> rtl/core/mte_ifs.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
// Depends on mte_pkg for the payload types.
`timescale 1ns / 1ps

interface mte_req_if import mte_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mte_res_if import mte_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mte_cfg_if import mte_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mte_csr_file.sv
// Trap state registers (status, epc, cause, tval, halt) and configuration registers.
// Depends on mte_pkg for csr_state_t and csr_update_t.
`timescale 1ns / 1ps

module mte_csr_file import mte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd_en,
	input  csr_update_t          upd,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output csr_state_t           state
);

	logic [31:0] status_q, epc_q, cause_q, tval_q, trap_vector_q;
	logic [2:0]  irq_enable_q;
	logic        stopped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			epc_q     <= '0;
			cause_q   <= '0;
			tval_q    <= '0;
			stopped_q <= 1'b0;
		end else if (upd_en) begin
			if (upd.commit) begin
				status_q <= upd.status;
				epc_q    <= upd.epc;
				cause_q  <= upd.cause;
				tval_q   <= upd.tval;
			end else if (upd.status_wr) begin
				status_q <= upd.status;
			end
			if (upd.halt) begin
				stopped_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trap_vector_q <= '0;
			irq_enable_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRAP_VECTOR: trap_vector_q <= cfg_data;
				CFG_IRQ_ENABLE:  irq_enable_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state.status      = status_q;
		state.epc         = epc_q;
		state.cause       = cause_q ^ (tval_q & 32'h0);
		state.trap_vector = trap_vector_q;
		state.irq_enable  = irq_enable_q;
		state.stopped     = stopped_q;
	end

endmodule

>>> rtl/core/mte_entry_logic.sv
// Combinational trap entry decision: interrupt priority, exception entry, status write.
// Depends on mte_pkg; produces the state update and the result for one request.
`timescale 1ns / 1ps

module mte_entry_logic import mte_pkg::*; (
	input  req_item_t   req_item,
	input  csr_state_t  state,
	output csr_update_t upd,
	output res_item_t   result
);

	logic [2:0]  active;
	logic        mie;
	logic        irq_hit;
	logic        entry;
	logic        no_handler;
	logic [3:0]  irq_code;
	logic [31:0] entry_cause;
	logic [31:0] entry_status;

	always_comb begin
		active = req_item.pending_lines & state.irq_enable;
		mie    = state.status[MSTATUS_MIE_BIT];

		// external beats software beats timer
		if (active[IRQ_LINE_EXTERNAL]) begin
			irq_code = IRQ_CAUSE_EXTERNAL;
		end else if (active[IRQ_LINE_SOFTWARE]) begin
			irq_code = IRQ_CAUSE_SOFTWARE;
		end else begin
			irq_code = IRQ_CAUSE_TIMER;
		end

		irq_hit       = 1'b0;
		entry         = 1'b0;
		upd.status_wr = 1'b0;
		unique case (req_item.command)
			CMD_IRQ_CHECK: begin
				irq_hit = mie && (active != 3'b000);
				entry   = irq_hit;
			end
			CMD_EXCEPTION: entry         = 1'b1;
			CMD_STATUS_WR: upd.status_wr = !state.stopped;
			default: ;
		endcase
		entry   = entry && !state.stopped;
		irq_hit = irq_hit && !state.stopped;

		no_handler = (state.trap_vector == 32'h0);
		entry_cause = irq_hit ? {1'b1, 27'h0, irq_code} : {28'h0, req_item.exception_cause};

		// MIE into MPIE, clear MIE, MPP to machine
		entry_status = (state.status & ~MSTATUS_CLEAR_MASK) | MSTATUS_MPP_MACHINE;
		entry_status[MSTATUS_MPIE_BIT] = mie;

		upd.commit = entry && !no_handler;
		upd.halt   = entry && no_handler;
		upd.status = upd.commit ? entry_status : req_item.status_value;
		upd.epc    = req_item.current_pc;
		upd.cause  = entry_cause;
		upd.tval   = irq_hit ? 32'h0 : req_item.fault_value;

		result.trap_taken      = entry;
		result.interrupt_taken = irq_hit;
		result.redirect_pc     = upd.commit ? (state.trap_vector & VECTOR_ALIGN_MASK)
		                                    : req_item.current_pc;
		result.halted_flag     = state.stopped || upd.halt;
		result.cause_now       = upd.commit ? entry_cause : state.cause;
		result.saved_pc        = upd.commit ? req_item.current_pc : state.epc;
		result.status_now      = (upd.commit || upd.status_wr) ? upd.status : state.status;
	end

endmodule

>>> rtl/core/machine_trap_entry_unit_top.sv
// The result of an accepted request is registered and shows on the result port from the cycle after acceptance.
// One request per cycle while the result register is empty or drains; the trap state and the result register are
// both written at the accepting edge, so the next request sees the updated state.
// The request side stays ready while the result register is empty or being drained.
// Reset (arst_n low, asynchronous) clears all trap state, config and the result valid.
// A halt after an entry with no handler holds until the next reset.
`timescale 1ns / 1ps

module machine_trap_entry_unit_top import mte_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	mte_req_if.sink  req,
	mte_res_if.source res,
	mte_cfg_if.sink  cfg
);

	csr_state_t  state;
	csr_update_t upd;
	res_item_t   result;
	res_item_t   res_q;
	logic        res_valid_q;
	logic        req_fire;

	// Accept a new request whenever the result register is free or drains this cycle.
	assign req.ready = !res_valid_q || res.ready;
	assign req_fire  = req.valid && req.ready;

	// Configuration writes are always taken; the user must send them only while the unit is idle (not enforced here).
	assign cfg.ready = 1'b1;

	mte_csr_file u_csr (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (req_fire),
		.upd       (upd),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.state     (state)
	);

	mte_entry_logic u_entry (
		.req_item (req.data),
		.state    (state),
		.upd      (upd),
		.result   (result)
	);

	// Result register: load on an accepted request, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; hold it while the sink stalls.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_q <= result;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Halt is sticky until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state.stopped |=> state.stopped)
		else $error("halt state cleared without reset");

	// A request taken while halted produces no trap.
	a_halted_no_trap: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && state.stopped) |=> (!res_q.trap_taken && res_q.halted_flag))
		else $error("trap reported while halted");

	// Interrupt entry is always a trap.
	a_irq_is_trap: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.interrupt_taken) |-> res_q.trap_taken)
		else $error("interrupt without trap");

	// A handled entry redirects to an aligned vector with MIE cleared.
	a_entry_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.trap_taken && !res_q.halted_flag)
		|-> (res_q.redirect_pc[1:0] == 2'b00 && !res_q.status_now[MSTATUS_MIE_BIT]))
		else $error("bad redirect or status after entry");

	// Result register is never overwritten while it holds an untaken result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !req_fire)
		else $error("request accepted over a stalled result");

endmodule
